// ----- sv/rpc_pkg.sv -----
// Shared codes and character constants for the rotor permutation cipher.
// No dependencies; used by the top level rotor_permutation_cipher.
package rpc_pkg;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_ROTOR = 2'd1;
  localparam logic [1:0] KIND_ENC   = 2'd2;

  localparam logic [1:0] SEL_LEFT  = 2'd0;
  localparam logic [1:0] SEL_RIGHT = 2'd1;
  localparam logic [1:0] SEL_REFL  = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BAD_SYM = 2'd1;
  localparam logic [1:0] STATUS_DUP     = 2'd2;

  localparam logic [7:0] SYM_BASE = 8'h31;
  localparam logic [7:0] CHAR_L   = 8'h4C;
  localparam logic [7:0] CHAR_R   = 8'h52;
  localparam logic [7:0] CHAR_T   = 8'h54;

endpackage

// ----- sv/rpc_table.sv -----
// One permutation store of the rotor cipher: one write port and one read
// port with registered read data. Standalone; instantiated by the top level.
module rpc_table #(
  parameter int Depth = 42,
  parameter int Width = 6
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- sv/rotor_permutation_cipher.sv -----
// Top level of the rotor permutation cipher: accept logic, rotor and seen
// state, and a seven-stage lookup pipeline. Depends on rpc_pkg and rpc_table.
//
//   channel | direction | handshake               | fields
//   --------+-----------+-------------------------+-----------------------------------
//   in      | to block  | in_valid_i / in_stall_o | kind, table_select, entry_index,
//           |           |                         | entry_value, left/right_position,
//           |           |                         | char_in
//   out     | from block| out_valid_o/out_stall_i | char_out, status
//
// One word is taken per cycle while in_stall_o is low; its result word passes in order through
// the input register, the five table lookups, each a registered memory read, and the
// result register.
// Reset clears the rotors and the seen marks; the tables hold nothing until loaded.
// A stalled result holds its stage; earlier stages keep filling until all are full.
module rotor_permutation_cipher #(
  parameter int ALPHABET_SIZE = 42
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] kind_i,
  input  logic [1:0] table_select_i,
  input  logic [5:0] entry_index_i,
  input  logic [7:0] entry_value_i,
  input  logic [7:0] left_position_i,
  input  logic [7:0] right_position_i,
  input  logic [7:0] char_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] char_out_o,
  output logic [1:0] status_o
);

  localparam int SymW = $clog2(ALPHABET_SIZE);
  localparam logic [SymW:0] NExt = (SymW+1)'(ALPHABET_SIZE);
  localparam logic [SymW-1:0] NotchL = SymW'(rpc_pkg::CHAR_L - rpc_pkg::SYM_BASE);
  localparam logic [SymW-1:0] NotchR = SymW'(rpc_pkg::CHAR_R - rpc_pkg::SYM_BASE);
  localparam logic [SymW-1:0] NotchT = SymW'(rpc_pkg::CHAR_T - rpc_pkg::SYM_BASE);

  typedef struct packed {
    logic            enc;
    logic [1:0]      status;
    logic [SymW-1:0] lrot;
    logic [SymW-1:0] rrot;
    logic [1:0]      sel;
    logic            wr;
    logic [SymW-1:0] idx;
    logic [SymW-1:0] val;
  } stage_t;

  function automatic logic [SymW-1:0] add_mod(input logic [SymW-1:0] a,
                                               input logic [SymW-1:0] b);
    logic [SymW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= NExt) s = s - NExt;
    return s[SymW-1:0];
  endfunction

  function automatic logic [SymW-1:0] sub_mod(input logic [SymW-1:0] a,
                                               input logic [SymW-1:0] b);
    logic [SymW:0] s;
    s = {1'b0, a} + NExt - {1'b0, b};
    if (s >= NExt) s = s - NExt;
    return s[SymW-1:0];
  endfunction

  function automatic logic sym_ok(input logic [7:0] c);
    logic [7:0] d;
    d = c - rpc_pkg::SYM_BASE;
    return (c >= rpc_pkg::SYM_BASE) && (d < 8'(ALPHABET_SIZE));
  endfunction

  logic [7:1] vld_q;
  logic [8:1] take;
  logic [7:1] load;

  stage_t ctl1_q, ctl2_q, ctl3_q, ctl4_q, ctl5_q, ctl6_q;
  logic [SymW-1:0] sym1_q;
  logic [SymW-1:0] rp_data, lp_data, rf_data, li_data, ri_data;
  logic [7:0] char_q;
  logic [1:0] status_q;

  logic [SymW-1:0] lrot_q, rrot_q;
  logic [2:0]      seen_q [ALPHABET_SIZE];

  stage_t          ctl1_d;
  logic [SymW-1:0] sym1_d;
  logic [SymW-1:0] lrot_d, rrot_d, rr_step, lr_step;
  logic [7:0]      ent_diff, chr_diff, lp_diff, rp_diff;
  logic [2:0]      seen_row;
  logic [7:0]      char_d;

  // Flow control: a stage takes a word when empty or when its word moves on.
  always_comb begin
    take[8] = !vld_q[7] || !out_stall_i;
    for (int k = 7; k >= 1; k--) begin
      take[k] = !vld_q[k] || take[k+1];
    end
    load[1] = in_valid_i && take[1];
    for (int k = 2; k <= 7; k++) begin
      load[k] = vld_q[k-1] && take[k];
    end
  end

  assign in_stall_o = !take[1];

  always_comb begin
    ent_diff = entry_value_i - rpc_pkg::SYM_BASE;
    chr_diff = char_in_i - rpc_pkg::SYM_BASE;
    lp_diff  = left_position_i - rpc_pkg::SYM_BASE;
    rp_diff  = right_position_i - rpc_pkg::SYM_BASE;
    seen_row = '0;
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      if (ent_diff == 8'(i)) seen_row = seen_q[i];
    end
    rr_step = add_mod(rrot_q, SymW'(1));
    if (rr_step == NotchL || rr_step == NotchR || rr_step == NotchT) begin
      lr_step = add_mod(lrot_q, SymW'(1));
    end else begin
      lr_step = lrot_q;
    end
    lrot_d = lrot_q;
    rrot_d = rrot_q;
    ctl1_d = '0;
    ctl1_d.sel = table_select_i;
    ctl1_d.idx = entry_index_i[SymW-1:0];
    ctl1_d.val = ent_diff[SymW-1:0];
    sym1_d = chr_diff[SymW-1:0];
    unique case (kind_i)
      rpc_pkg::KIND_LOAD: begin
        if (!sym_ok(entry_value_i)) begin
          ctl1_d.status = rpc_pkg::STATUS_BAD_SYM;
        end else if (table_select_i <= rpc_pkg::SEL_REFL &&
                     entry_index_i < 6'(ALPHABET_SIZE)) begin
          if (seen_row[table_select_i]) begin
            ctl1_d.status = rpc_pkg::STATUS_DUP;
          end else begin
            ctl1_d.wr = 1'b1;
          end
        end
      end
      rpc_pkg::KIND_ROTOR: begin
        if (sym_ok(left_position_i) && sym_ok(right_position_i)) begin
          lrot_d = lp_diff[SymW-1:0];
          rrot_d = rp_diff[SymW-1:0];
        end else begin
          ctl1_d.status = rpc_pkg::STATUS_BAD_SYM;
        end
      end
      rpc_pkg::KIND_ENC: begin
        if (sym_ok(char_in_i)) begin
          lrot_d     = lr_step;
          rrot_d     = rr_step;
          ctl1_d.enc = 1'b1;
        end else begin
          ctl1_d.status = rpc_pkg::STATUS_BAD_SYM;
        end
      end
      default: begin
      end
    endcase
    ctl1_d.lrot = lrot_d;
    ctl1_d.rrot = rrot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      lrot_q <= '0;
      rrot_q <= '0;
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
        seen_q[i] <= '0;
      end
    end else begin
      if (take[1]) vld_q[1] <= in_valid_i;
      for (int k = 2; k <= 7; k++) begin
        if (take[k]) vld_q[k] <= vld_q[k-1];
      end
      if (load[1]) begin
        lrot_q <= lrot_d;
        rrot_q <= rrot_d;
        if (ctl1_d.wr) seen_q[ctl1_d.val][ctl1_d.sel] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[1]) begin
      ctl1_q <= ctl1_d;
      sym1_q <= sym1_d;
    end
    if (load[2]) ctl2_q <= ctl1_q;
    if (load[3]) ctl3_q <= ctl2_q;
    if (load[4]) ctl4_q <= ctl3_q;
    if (load[5]) ctl5_q <= ctl4_q;
    if (load[6]) ctl6_q <= ctl5_q;
    if (load[7]) begin
      char_q   <= char_d;
      status_q <= ctl6_q.status;
    end
  end

  assign char_d = ctl6_q.enc ? 8'(sub_mod(ri_data, ctl6_q.rrot)) + rpc_pkg::SYM_BASE
                             : 8'd0;

  rpc_table #(.Depth(ALPHABET_SIZE), .Width(SymW)) u_right_perm (
    .clk_i     (clk_i),
    .rd_en_i   (load[2]),
    .wr_en_i   (load[2] && ctl1_q.wr && ctl1_q.sel == rpc_pkg::SEL_RIGHT),
    .wr_addr_i (ctl1_q.idx),
    .wr_data_i (ctl1_q.val),
    .rd_addr_i (add_mod(sym1_q, ctl1_q.rrot)),
    .rd_data_o (rp_data)
  );

  rpc_table #(.Depth(ALPHABET_SIZE), .Width(SymW)) u_left_perm (
    .clk_i     (clk_i),
    .rd_en_i   (load[3]),
    .wr_en_i   (load[3] && ctl2_q.wr && ctl2_q.sel == rpc_pkg::SEL_LEFT),
    .wr_addr_i (ctl2_q.idx),
    .wr_data_i (ctl2_q.val),
    .rd_addr_i (add_mod(sub_mod(rp_data, ctl2_q.rrot), ctl2_q.lrot)),
    .rd_data_o (lp_data)
  );

  rpc_table #(.Depth(ALPHABET_SIZE), .Width(SymW)) u_reflector (
    .clk_i     (clk_i),
    .rd_en_i   (load[4]),
    .wr_en_i   (load[4] && ctl3_q.wr && ctl3_q.sel == rpc_pkg::SEL_REFL),
    .wr_addr_i (ctl3_q.idx),
    .wr_data_i (ctl3_q.val),
    .rd_addr_i (sub_mod(lp_data, ctl3_q.lrot)),
    .rd_data_o (rf_data)
  );

  rpc_table #(.Depth(ALPHABET_SIZE), .Width(SymW)) u_left_inverse (
    .clk_i     (clk_i),
    .rd_en_i   (load[5]),
    .wr_en_i   (load[5] && ctl4_q.wr && ctl4_q.sel == rpc_pkg::SEL_LEFT),
    .wr_addr_i (ctl4_q.val),
    .wr_data_i (ctl4_q.idx),
    .rd_addr_i (add_mod(rf_data, ctl4_q.lrot)),
    .rd_data_o (li_data)
  );

  rpc_table #(.Depth(ALPHABET_SIZE), .Width(SymW)) u_right_inverse (
    .clk_i     (clk_i),
    .rd_en_i   (load[6]),
    .wr_en_i   (load[6] && ctl5_q.wr && ctl5_q.sel == rpc_pkg::SEL_RIGHT),
    .wr_addr_i (ctl5_q.val),
    .wr_data_i (ctl5_q.idx),
    .rd_addr_i (add_mod(sub_mod(li_data, ctl5_q.lrot), ctl5_q.rrot)),
    .rd_data_o (ri_data)
  );

  assign out_valid_o = vld_q[7];
  assign char_out_o  = char_q;
  assign status_o    = status_q;

  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (vld_q == '1 && out_stall_i))
    else $error("input stalled while the pipeline has room");

  a_error_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != rpc_pkg::STATUS_OK) |-> (char_out_o == 8'd0))
    else $error("error word carries a character");

  a_rotor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lrot_q < SymW'(ALPHABET_SIZE)) && (rrot_q < SymW'(ALPHABET_SIZE)))
    else $error("rotor position beyond the alphabet");

  a_rotor_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load[1] |=> ($stable(lrot_q) && $stable(rrot_q)))
    else $error("rotor moved without an accepted word");

endmodule
